/* rtl/upd_pkg.sv */
// Shared types, codes and character tables of the URL percent decoder.
// No dependencies; used by upd_parser, upd_emitter, url_percent_decoder_unit and the test files.
package upd_pkg;

  // Parser state, one-hot
  typedef enum logic [4:0] {
    MODE_PATH  = 5'b00001,
    MODE_HEX1  = 5'b00010,
    MODE_HEX2  = 5'b00100,
    MODE_QUERY = 5'b01000,
    MODE_ERROR = 5'b10000
  } mode_t;

  // Result part codes
  localparam logic [1:0] PART_PATH  = 2'd0;
  localparam logic [1:0] PART_QUERY = 2'd1;
  localparam logic [1:0] PART_END   = 2'd2;

  // End marker status codes
  localparam logic [1:0] STAT_STATIC  = 2'd0;
  localparam logic [1:0] STAT_DYNAMIC = 2'd1;
  localparam logic [1:0] STAT_BADESC  = 2'd2;

  // Special characters
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_QMARK   = 8'h3F;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_LOWER_C = 8'h63;

  // Length of the substring scanned for dynamic content
  localparam logic [2:0] CGI_LEN = 3'd7;

  // Emitter step codes: main byte, first and last suffix char, end marker
  localparam logic [3:0] STEP_MAIN = 4'd0;
  localparam logic [3:0] STEP_IDX0 = 4'd1;
  localparam logic [3:0] STEP_IDXN = 4'd10;
  localparam logic [3:0] STEP_END  = 4'd11;

  // One unit of output work handed from parser to emitter
  typedef struct packed {
    logic       has_byte;
    logic [7:0] byte_val;
    logic [1:0] part;
    logic       fin;
    logic       app;
    logic [1:0] status;
  } job_t;

  // Characters of "cgi-bin"
  function automatic logic [7:0] cgi_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h63; // c
      3'd1:    ch = 8'h67; // g
      3'd2:    ch = 8'h69; // i
      3'd3:    ch = 8'h2D; // -
      3'd4:    ch = 8'h62; // b
      3'd5:    ch = 8'h69; // i
      3'd6:    ch = 8'h6E; // n
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Characters of "index.html"
  function automatic logic [7:0] index_char(input logic [3:0] idx);
    logic [7:0] ch;
    unique case (idx)
      4'd0:    ch = 8'h69; // i
      4'd1:    ch = 8'h6E; // n
      4'd2:    ch = 8'h64; // d
      4'd3:    ch = 8'h65; // e
      4'd4:    ch = 8'h78; // x
      4'd5:    ch = 8'h2E; // .
      4'd6:    ch = 8'h68; // h
      4'd7:    ch = 8'h74; // t
      4'd8:    ch = 8'h6D; // m
      4'd9:    ch = 8'h6C; // l
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Hex digit decode: {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] ch);
    logic [4:0] r;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      r = {1'b1, 4'(ch - 8'h30)};
    end else if (ch >= 8'h61 && ch <= 8'h66) begin
      r = {1'b1, 4'(ch - 8'h57)};
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      r = {1'b1, 4'(ch - 8'h37)};
    end else begin
      r = 5'd0;
    end
    return r;
  endfunction

endpackage

/* rtl/url_percent_decoder_unit.sv */
// URL percent decoder top level: one raw URI byte per request in, decoded results out.
// Results are registered: a result appears in the cycle after its request is accepted.
// Throughput: one request per cycle while out_ready is high; a final byte holds off input
// while the result register plays out the byte, "index.html" if appended, and the end marker.
// Reset (rst_n, synchronous): parser state to path mode, result register empty.
// Depends on upd_pkg, upd_parser, upd_emitter.
module url_percent_decoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_uri_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] out_part,
  output logic [1:0] out_status,
  output logic       out_done_res
);
  import upd_pkg::*;

  job_t job;
  logic job_ok;
  logic room;
  logic acc;

  assign in_ready = room;
  assign acc      = in_valid && room;

  upd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .in_byte    (in_byte),
    .in_uri_end (in_uri_end),
    .job        (job),
    .job_ok     (job_ok)
  );

  upd_emitter u_emitter (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (acc && job_ok),
    .job          (job),
    .room         (room),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_part     (out_part),
    .out_status   (out_status),
    .out_done_res (out_done_res)
  );

endmodule

/* rtl/upd_parser.sv */
// Parser of the URL percent decoder: escape decode, mode tracking, cgi-bin scan.
// Depends on upd_pkg. Produces one job_t per accepted request that emits a byte or ends the URI.
module upd_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc,
  input  logic [7:0]       in_byte,
  input  logic             in_uri_end,
  output upd_pkg::job_t    job,
  output logic             job_ok
);
  import upd_pkg::*;

  mode_t      mode_r, mode_nxt;
  logic [3:0] nib_r, nib_nxt;
  logic [2:0] match_r, match_nxt;
  logic       saw_r, saw_nxt;
  logic       slash_r, slash_nxt;

  logic [2:0] p;
  logic       saw_cur;
  logic [4:0] hx;
  logic       emit;
  logic [7:0] emit_byte;
  logic [1:0] emit_part;
  logic       err;

  always_comb begin
    // substring scan runs over every raw byte
    saw_cur = saw_r;
    if (in_byte == cgi_char(match_r)) begin
      p = 3'(match_r + 3'd1);
    end else begin
      p = (in_byte == CH_LOWER_C) ? 3'd1 : 3'd0;
    end
    if (p == CGI_LEN) begin
      saw_cur = 1'b1;
      p       = 3'd0;
    end

    // mode handling
    hx        = hex_digit(in_byte);
    mode_nxt  = mode_r;
    nib_nxt   = nib_r;
    slash_nxt = slash_r;
    emit      = 1'b0;
    emit_byte = in_byte;
    emit_part = PART_PATH;
    unique case (mode_r)
      MODE_PATH: begin
        priority if (in_byte == CH_PERCENT) begin
          mode_nxt = MODE_HEX1;
        end else if (in_byte == CH_PLUS) begin
          emit      = 1'b1;
          emit_byte = CH_SPACE;
        end else if (in_byte == CH_QMARK) begin
          mode_nxt = MODE_QUERY;
        end else begin
          emit = 1'b1;
        end
      end
      MODE_HEX1: begin
        if (hx[4]) begin
          nib_nxt  = hx[3:0];
          mode_nxt = MODE_HEX2;
        end else begin
          mode_nxt = MODE_ERROR;
        end
      end
      MODE_HEX2: begin
        if (hx[4]) begin
          emit      = 1'b1;
          emit_byte = {nib_r, hx[3:0]};
          mode_nxt  = MODE_PATH;
        end else begin
          mode_nxt = MODE_ERROR;
        end
      end
      MODE_QUERY: begin
        emit      = 1'b1;
        emit_part = PART_QUERY;
      end
      MODE_ERROR: begin
        mode_nxt = MODE_ERROR;
      end
      default: begin
        mode_nxt = MODE_ERROR;
      end
    endcase
    if (emit && emit_part == PART_PATH) begin
      slash_nxt = (emit_byte == CH_SLASH);
    end

    // end of URI: unfinished escape is an error
    err = (mode_nxt == MODE_ERROR) || (mode_nxt == MODE_HEX1) || (mode_nxt == MODE_HEX2);

    job.has_byte = emit;
    job.byte_val = emit_byte;
    job.part     = emit_part;
    job.fin      = in_uri_end;
    job.app      = !err && slash_nxt;
    job.status   = err ? STAT_BADESC : (saw_cur ? STAT_DYNAMIC : STAT_STATIC);
    job_ok       = emit || in_uri_end;

    match_nxt = p;
    saw_nxt   = saw_cur;
  end

  // state registers; a final byte returns everything to reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_PATH;
      nib_r   <= 4'd0;
      match_r <= 3'd0;
      saw_r   <= 1'b0;
      slash_r <= 1'b0;
    end else if (acc) begin
      if (in_uri_end) begin
        mode_r  <= MODE_PATH;
        nib_r   <= 4'd0;
        match_r <= 3'd0;
        saw_r   <= 1'b0;
        slash_r <= 1'b0;
      end else begin
        mode_r  <= mode_nxt;
        nib_r   <= nib_nxt;
        match_r <= match_nxt;
        saw_r   <= saw_nxt;
        slash_r <= slash_nxt;
      end
    end
  end

endmodule

/* rtl/upd_emitter.sv */
// Result register and tail sequencer: main byte, optional "index.html", end marker.
// Depends on upd_pkg.
module upd_emitter (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  upd_pkg::job_t    job,
  output logic             room,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic [1:0]       out_part,
  output logic [1:0]       out_status,
  output logic             out_done_res
);
  import upd_pkg::*;

  logic       vld_r;
  job_t       job_r;
  logic [3:0] step_r, step_nxt, start;
  logic       last_emit;
  logic       take;

  always_comb begin
    // first step of a freshly loaded job
    if (job.has_byte) begin
      start = STEP_MAIN;
    end else if (job.app) begin
      start = STEP_IDX0;
    end else begin
      start = STEP_END;
    end

    // step after the current one
    if (step_r == STEP_MAIN) begin
      step_nxt = job_r.app ? STEP_IDX0 : STEP_END;
    end else if (step_r == STEP_IDXN) begin
      step_nxt = STEP_END;
    end else begin
      step_nxt = 4'(step_r + 4'd1);
    end

    last_emit = (step_r == STEP_END) || (step_r == STEP_MAIN && !job_r.fin);
    take      = vld_r && out_ready;
    room      = !vld_r || (out_ready && last_emit);

    // output mux
    out_valid    = vld_r;
    out_status   = STAT_STATIC;
    out_done_res = 1'b0;
    if (step_r == STEP_MAIN) begin
      out_byte = job_r.byte_val;
      out_part = job_r.part;
    end else if (step_r == STEP_END) begin
      out_byte     = 8'd0;
      out_part     = PART_END;
      out_status   = job_r.status;
      out_done_res = 1'b1;
    end else begin
      out_byte = index_char(4'(step_r - STEP_IDX0));
      out_part = PART_PATH;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      step_r <= STEP_MAIN;
    end else if (load) begin
      vld_r  <= 1'b1;
      step_r <= start;
    end else if (take && last_emit) begin
      vld_r <= 1'b0;
    end else if (take) begin
      step_r <= step_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      job_r <= job;
    end
  end

endmodule

/* test/upd_result_checker.sv */
// Checker for the URL percent decoder: watches the request and result channels, predicts
// the decoded results of every accepted byte and compares them in order.
// Depends on upd_pkg for part, status and parser mode codes.
module upd_result_checker
  import upd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_uri_end,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic [1:0] out_part,
  input  logic [1:0] out_status,
  input  logic       out_done_res,
  output int         fail_count,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] val;
    logic [1:0] part;
    logic [1:0] status;
    logic       done;
  } dec_result_t;

  // "cgi-bin" and "index.html"
  localparam logic [7:0] DYN_TAG [0:6] = '{8'h63, 8'h67, 8'h69, 8'h2D, 8'h62, 8'h69, 8'h6E};
  localparam logic [7:0] INDEX_SFX [0:9] = '{8'h69, 8'h6E, 8'h64, 8'h65, 8'h78,
                                             8'h2E, 8'h68, 8'h74, 8'h6D, 8'h6C};

  // Predicted parser state
  mode_t       mode;
  logic [3:0]  hi_nib;
  logic [2:0]  tag_pos;
  logic        dyn_seen;
  logic        ends_slash;

  dec_result_t decoded_q[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic int nibble_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 8'h30;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 8'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 8'h41 + 10;
    return -1;
  endfunction

  task automatic clear_uri_state();
    mode       = MODE_PATH;
    hi_nib     = 4'd0;
    tag_pos    = 3'd0;
    dyn_seen   = 1'b0;
    ends_slash = 1'b0;
  endtask

  task automatic put_result(input logic [7:0] v, input logic [1:0] p,
                            input logic [1:0] s, input logic d);
    decoded_q.push_back('{val: v, part: p, status: s, done: d});
  endtask

  task automatic put_path(input logic [7:0] v);
    put_result(v, PART_PATH, STAT_STATIC, 1'b0);
    ends_slash = (v == CH_SLASH);
  endtask

  // Work out every result caused by one accepted byte
  task automatic decode_byte(input logic [7:0] c, input logic last);
    logic [2:0] p;
    logic [1:0] st;
    int         hv;
    // substring scan runs on every raw byte, dropped ones included
    p = tag_pos;
    if (p > 3'd6) p = 3'd0;
    if (c == DYN_TAG[p]) p = p + 3'd1;
    else p = (c == CH_LOWER_C) ? 3'd1 : 3'd0;
    if (p == CGI_LEN) begin
      dyn_seen = 1'b1;
      p = 3'd0;
    end
    tag_pos = p;

    hv = nibble_of(c);
    case (mode)
      MODE_PATH: begin
        if (c == CH_PERCENT) mode = MODE_HEX1;
        else if (c == CH_PLUS) put_path(CH_SPACE);
        else if (c == CH_QMARK) mode = MODE_QUERY;
        else put_path(c);
      end
      MODE_HEX1: begin
        if (hv < 0) begin
          mode = MODE_ERROR;
        end else begin
          hi_nib = hv[3:0];
          mode = MODE_HEX2;
        end
      end
      MODE_HEX2: begin
        if (hv < 0) begin
          mode = MODE_ERROR;
        end else begin
          put_path({hi_nib, hv[3:0]});
          mode = MODE_PATH;
        end
      end
      MODE_QUERY: put_result(c, PART_QUERY, STAT_STATIC, 1'b0);
      default: mode = MODE_ERROR;
    endcase

    // end of URI: escape cut short is an error, else maybe append index.html
    if (last) begin
      if (mode == MODE_HEX1 || mode == MODE_HEX2) mode = MODE_ERROR;
      if (mode == MODE_ERROR) begin
        st = STAT_BADESC;
      end else begin
        if (ends_slash) begin
          for (int i = 0; i < 10; i++) put_result(INDEX_SFX[i], PART_PATH, STAT_STATIC, 1'b0);
        end
        st = dyn_seen ? STAT_DYNAMIC : STAT_STATIC;
      end
      put_result(8'h00, PART_END, st, 1'b1);
      clear_uri_state();
    end
  endtask

  task automatic check_result();
    dec_result_t w;
    if (decoded_q.size() == 0) begin
      $error("unexpected result: out_byte=%h out_part=%0d out_status=%0d out_done_res=%0b",
             out_byte, out_part, out_status, out_done_res);
      fail_count++;
    end else begin
      w = decoded_q.pop_front();
      if (out_byte !== w.val) begin
        $error("out_byte: expected %h, got %h", w.val, out_byte);
        fail_count++;
      end
      if (out_part !== w.part) begin
        $error("out_part: expected %0d, got %0d", w.part, out_part);
        fail_count++;
      end
      if (out_status !== w.status) begin
        $error("out_status: expected %0d, got %0d", w.status, out_status);
        fail_count++;
      end
      if (out_done_res !== w.done) begin
        $error("out_done_res: expected %0b, got %0b", w.done, out_done_res);
        fail_count++;
      end
    end
  endtask

  // Results are checked before the new request is predicted, so a result
  // never meets an expectation queued at the same edge
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_uri_state();
      decoded_q.delete();
    end else begin
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) decode_byte(in_byte, in_uri_end);
    end
    pending = decoded_q.size();
  end

endmodule

/* test/url_percent_decoder_unit_tb.sv */
// Testbench top for url_percent_decoder_unit: clock, reset, byte requests and
// result-side stalls; prediction and comparison live in upd_result_checker.
// Depends on upd_pkg, upd_result_checker and the decoder RTL.
module url_percent_decoder_unit_tb
  import upd_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       in_uri_end;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic [1:0] out_part;
  logic [1:0] out_status;
  logic       out_done_res;

  int fail_count;
  int pending;
  int bytes_sent;
  bit hold_rx;

  logic [7:0] uri_q[$];

  string plain_chars = "abcgin-_.~09XYZ/";
  string bad_chars   = "gGzZ+%?/ -";

  url_percent_decoder_unit DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .in_uri_end  (in_uri_end),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .out_part    (out_part),
    .out_status  (out_status),
    .out_done_res(out_done_res)
  );

  upd_result_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .in_uri_end  (in_uri_end),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .out_part    (out_part),
    .out_status  (out_status),
    .out_done_res(out_done_res),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Run limit, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("FAIL url_percent_decoder_unit");
    $finish;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 92) return $urandom_range(4, 8);
    return $urandom_range(12, 30);
  endfunction

  function automatic logic [7:0] hex_char(input int v, input bit upper);
    if (v < 10) return 8'h30 + v[7:0];
    return (upper ? 8'h41 : 8'h61) + v[7:0] - 8'd10;
  endfunction

  // Result side: random stalls, calm stretches, one long hold on request
  initial begin
    int rx_idle;
    int rx_cycle;
    bit rx_calm;
    rx_idle  = 0;
    rx_cycle = 0;
    rx_calm  = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (rx_cycle % 100 == 0) rx_calm = ($urandom_range(0, 2) == 0);
      if (hold_rx) begin
        out_ready <= 1'b0;
        repeat (80) @(posedge clk);
        hold_rx = 1'b0;
      end else if (rx_idle > 0) begin
        out_ready <= 1'b0;
        rx_idle--;
      end else begin
        out_ready <= 1'b1;
        if (!rx_calm && $urandom_range(0, 3) == 0) rx_idle = pick_gap();
      end
    end
  end

  // One byte request; valid stays high across back-to-back requests
  task automatic send_item(input logic [7:0] b, input logic last, input bit no_gap);
    int g;
    g = 0;
    if (!no_gap && $urandom_range(0, 2) == 0) g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_byte    <= b;
    in_uri_end <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_uri();
    bit no_gap;
    no_gap = ($urandom_range(0, 3) == 0);
    foreach (uri_q[i]) send_item(uri_q[i], i == uri_q.size() - 1, no_gap);
    uri_q.delete();
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) uri_q.push_back(s[i]);
  endtask

  task automatic run_str(input string s);
    push_str(s);
    send_uri();
  endtask

  // Random URI: mostly well-formed, some broken escapes, some raw noise
  task automatic build_uri();
    int kind;
    int pieces;
    int v;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 8)) uri_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      pieces = $urandom_range(0, 5);
      repeat (pieces) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: uri_q.push_back(plain_chars[$urandom_range(0, plain_chars.len() - 1)]);
          4: uri_q.push_back(CH_SLASH);
          5: uri_q.push_back(CH_PLUS);
          6: begin
            uri_q.push_back(CH_PERCENT);
            uri_q.push_back(hex_char($urandom_range(0, 15), 1'($urandom_range(0, 1))));
            uri_q.push_back(hex_char($urandom_range(0, 15), 1'($urandom_range(0, 1))));
          end
          7: push_str("cgi-bin");
          8: uri_q.push_back(CH_QMARK);
          default: uri_q.push_back(8'($urandom_range(0, 255)));
        endcase
      end
      if (kind == 1) begin
        // broken escape: bad digit, or cut short by the end of the URI
        case ($urandom_range(0, 2))
          0: begin
            uri_q.push_back(CH_PERCENT);
            if ($urandom_range(0, 1)) uri_q.push_back(hex_char($urandom_range(0, 15), 1'b0));
            uri_q.push_back(bad_chars[$urandom_range(0, bad_chars.len() - 1)]);
            repeat ($urandom_range(0, 3)) uri_q.push_back(8'($urandom_range(0, 255)));
          end
          1: uri_q.push_back(CH_PERCENT);
          default: begin
            v = $urandom_range(0, 15);
            uri_q.push_back(CH_PERCENT);
            uri_q.push_back(hex_char(v, 1'($urandom_range(0, 1))));
          end
        endcase
      end else if ($urandom_range(0, 2) == 0) begin
        uri_q.push_back(CH_SLASH);
      end
    end
    if (uri_q.size() == 0) uri_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // Stimulus and verdict
  initial begin
    bit held;
    bit drained;
    held       = 1'b0;
    drained    = 1'b0;
    hold_rx    = 1'b0;
    bytes_sent = 0;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_byte    <= 8'h00;
    in_uri_end <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // decoded slash ends the path: index.html appended, longest burst
    run_str("/%2f");
    // plus to space, then bad digit with later bytes dropped
    run_str("+%zz");
    // byte extremes, then escape cut short at the end
    uri_q.push_back(8'h00);
    uri_q.push_back(8'hFF);
    push_str("%4");
    send_uri();
    // mixed-case escape, slash, then query switch on the last byte
    run_str("%Af/?");
    // empty path, dynamic tag inside the query
    run_str("?cgi-bin");

    while (bytes_sent < 470) begin
      if (!held && bytes_sent >= 150) begin
        hold_rx = 1'b1;
        held = 1'b1;
      end
      if (!drained && bytes_sent >= 310) begin
        // sender pauses until everything predicted has come out
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (15) @(posedge clk);
        drained = 1'b1;
      end
      build_uri();
      send_uri();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS url_percent_decoder_unit");
    end else begin
      $display("FAIL url_percent_decoder_unit");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/upd_pkg.sv
rtl/upd_parser.sv
rtl/upd_emitter.sv
rtl/url_percent_decoder_unit.sv
test/upd_result_checker.sv
test/url_percent_decoder_unit_tb.sv
